FILE: rtl/esc_pkg.sv
package esc_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_TRIM_T  = 3'd0,
    REG_TRIM_PL = 3'd1,
    REG_TRIM_PH = 3'd2,
    REG_TRIM_MX = 3'd3,
    REG_TRIM_H  = 3'd4
  } esc_reg_t;

  localparam int DIV_W = 32;

  // humidity ceiling before the final scaling
  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  // trimming values, each widened to a 32-bit pattern
  typedef struct packed {
    logic signed [31:0] t1, t2, t3;
    logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
  } esc_trim_t;

  // data that rides along the divider with each item
  typedef struct packed {
    logic               skip;
    logic [15:0]        temp;
    logic signed [31:0] hv;
    logic               dz;
    logic               mul2;
  } esc_side_t;

  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic esc_trim_t decode_trim(
    input logic [47:0] rt, input logic [63:0] rpl, input logic [63:0] rph,
    input logic [47:0] rmx, input logic [39:0] rh);
    esc_trim_t t;
    t.t1 = {16'b0, rt[15:0]};
    t.t2 = sx16(rt[31:16]);
    t.t3 = sx16(rt[47:32]);
    t.p1 = {16'b0, rpl[15:0]};
    t.p2 = sx16(rpl[31:16]);
    t.p3 = sx16(rpl[47:32]);
    t.p4 = sx16(rpl[63:48]);
    t.p5 = sx16(rph[15:0]);
    t.p6 = sx16(rph[31:16]);
    t.p7 = sx16(rph[47:32]);
    t.p8 = sx16(rph[63:48]);
    t.p9 = sx16(rmx[15:0]);
    t.h1 = {24'b0, rmx[23:16]};
    t.h2 = sx16(rmx[39:24]);
    t.h3 = {24'b0, rmx[47:40]};
    t.h4 = sx16(rh[15:0]);
    t.h5 = sx16(rh[31:16]);
    t.h6 = {{24{rh[39]}}, rh[39:32]};
    decode_trim = t;
  endfunction

endpackage

FILE: rtl/esc_if.sv
interface esc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  logic [15:0] raw_humidity;
  modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface esc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] temperature_centi_c;
  logic [13:0] humidity_centi_pct;
  logic [31:0] pressure_pa;
  logic        pressure_valid;
  logic        reading_valid;
  modport source (output valid, temperature_centi_c, humidity_centi_pct, pressure_pa,
                  pressure_valid, reading_valid, input ready);
  modport sink (input valid, temperature_centi_c, humidity_centi_pct, pressure_pa,
                pressure_valid, reading_valid, output ready);
endinterface

interface esc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/esc_front.sv
module esc_front import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  esc_trim_t          trim,
  input  logic               in_valid,
  input  logic [19:0]        raw_pressure,
  input  logic [19:0]        raw_temperature,
  input  logic [15:0]        raw_humidity,
  output logic               out_valid,
  output logic [31:0]        dividend,
  output logic [31:0]        divisor,
  output esc_side_t          side
);

  logic [11:1] vld;

  logic signed [31:0] at32, q1c_w, q4_w, e_w, q1p_w, pn_w;

  logic signed [31:0] s1_x1, s1_d;
  logic [15:0] s1_ah, s2_ah, s3_ah, s4_ah, s5_ah, s6_ah;
  logic [19:0] s1_ap, s2_ap, s3_ap, s4_ap, s5_ap, s6_ap, s7_ap, s8_ap, s9_ap;
  logic [10:1] skp;
  logic signed [31:0] s2_m1, s2_dd, s3_v1, s3_m2, s4_tf;
  logic [15:0] tmp5, tmp6, tmp7, tmp8, tmp9, tmp10;
  logic signed [31:0] s5_v, s5_q1, s5_q4;
  logic signed [31:0] s6_hm, s6_bm, s6_cm, s6_sq, s6_pm5, s6_pm2;
  logic signed [31:0] s7_a, s7_b, s7_c, s7_q2a, s7_p3m, s7_pm5, s7_pm2;
  logic signed [31:0] s8_em, s8_q2, s8_q1b, s8_a;
  logic signed [31:0] s9_fm, s9_q1c, s9_a, s9_q2;
  logic signed [31:0] s10_f, s10_q1, s10_pnum, s10_a;

  assign at32  = {12'b0, raw_temperature};
  assign q1c_w = (s4_tf >>> 1) - 32'sd64000;
  assign q4_w  = q1c_w >>> 2;
  assign e_w   = (s8_em >>> 10) + 32'sd2097152;
  assign q1p_w = 32'sd32768 + s8_q1b;
  assign pn_w  = 32'sd1048576 - $signed({12'b0, s9_ap}) - (s9_q2 >>> 12);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[10:1], in_valid};
    end
  end

  // temperature, then humidity and pressure coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1 <= (at32 >>> 3) - (trim.t1 <<< 1);
      s1_d  <= (at32 >>> 4) - trim.t1;
      s1_ah <= raw_humidity;
      s1_ap <= raw_pressure;
      skp   <= {skp[9:1],
                (raw_temperature == 20'h80000) || (raw_humidity == 16'h8000)};

      s2_m1 <= s1_x1 * trim.t2;
      s2_dd <= s1_d * s1_d;
      s2_ah <= s1_ah;
      s2_ap <= s1_ap;

      s3_v1 <= s2_m1 >>> 11;
      s3_m2 <= (s2_dd >>> 12) * trim.t3;
      s3_ah <= s2_ah;
      s3_ap <= s2_ap;

      s4_tf <= s3_v1 + (s3_m2 >>> 14);
      s4_ah <= s3_ah;
      s4_ap <= s3_ap;

      tmp5  <= 16'(((s4_tf * 32'sd5) + 32'sd128) >>> 8);
      s5_v  <= s4_tf - 32'sd76800;
      s5_q1 <= q1c_w;
      s5_q4 <= q4_w;
      s5_ah <= s4_ah;
      s5_ap <= s4_ap;

      s6_hm  <= trim.h5 * s5_v;
      s6_bm  <= s5_v * trim.h6;
      s6_cm  <= s5_v * trim.h3;
      s6_sq  <= s5_q4 * s5_q4;
      s6_pm5 <= s5_q1 * trim.p5;
      s6_pm2 <= trim.p2 * s5_q1;
      tmp6   <= tmp5;
      s6_ah  <= s5_ah;
      s6_ap  <= s5_ap;

      s7_a   <= ($signed({2'b0, s6_ah, 14'b0}) - (trim.h4 <<< 20) - s6_hm
                 + 32'sd16384) >>> 15;
      s7_b   <= s6_bm >>> 10;
      s7_c   <= (s6_cm >>> 11) + 32'sd32768;
      s7_q2a <= (s6_sq >>> 11) * trim.p6;
      s7_p3m <= trim.p3 * (s6_sq >>> 13);
      s7_pm5 <= s6_pm5;
      s7_pm2 <= s6_pm2;
      tmp7   <= tmp6;
      s7_ap  <= s6_ap;

      s8_em  <= s7_b * s7_c;
      s8_q2  <= ((s7_q2a + (s7_pm5 <<< 1)) >>> 2) + (trim.p4 <<< 16);
      s8_q1b <= ((s7_p3m >>> 3) + (s7_pm2 >>> 1)) >>> 18;
      s8_a   <= s7_a;
      tmp8   <= tmp7;
      s8_ap  <= s7_ap;

      s9_fm  <= e_w * trim.h2;
      s9_q1c <= q1p_w * trim.p1;
      s9_a   <= s8_a;
      s9_q2  <= s8_q2;
      tmp9   <= tmp8;
      s9_ap  <= s8_ap;

      s10_f    <= (s9_fm + 32'sd8192) >>> 14;
      s10_q1   <= s9_q1c >>> 15;
      s10_pnum <= pn_w * 32'sd3125;
      s10_a    <= s9_a;
      tmp10    <= tmp9;

      // divider feed
      side.hv   <= s10_a * s10_f;
      side.temp <= tmp10;
      side.skip <= skp[10];
      side.dz   <= (s10_q1 == 32'sd0);
      side.mul2 <= s10_pnum[31];
      dividend  <= s10_pnum[31] ? s10_pnum : (s10_pnum <<< 1);
      divisor   <= s10_q1;
    end
  end

  assign out_valid = vld[11];

endmodule

FILE: rtl/esc_div.sv
module esc_div import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  esc_side_t   in_side,
  output logic        out_valid,
  output logic [31:0] quotient,
  output esc_side_t   out_side
);

  logic [DIV_W:0]  st_valid;
  logic [31:0]     st_rem  [DIV_W+1];
  logic [31:0]     st_quo  [DIV_W+1];
  logic [31:0]     st_dvs  [DIV_W+1];
  esc_side_t       st_side [DIV_W+1];

  assign st_valid[0] = in_valid;
  assign st_rem[0]   = '0;
  assign st_quo[0]   = dividend;
  assign st_dvs[0]   = divisor;
  assign st_side[0]  = in_side;

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [32:0] shifted;
    logic [33:0] diff;
    assign shifted = {st_rem[k], st_quo[k][31]};
    assign diff    = {1'b0, shifted} - {2'b0, st_dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (en) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[33]) begin
          st_rem[k+1] <= diff[31:0];
          st_quo[k+1] <= {st_quo[k][30:0], 1'b1};
        end else begin
          st_rem[k+1] <= shifted[31:0];
          st_quo[k+1] <= {st_quo[k][30:0], 1'b0};
        end
        st_dvs[k+1]  <= st_dvs[k];
        st_side[k+1] <= st_side[k];
      end
    end
  end

  assign out_valid = st_valid[DIV_W];
  assign quotient  = st_quo[DIV_W];
  assign out_side  = st_side[DIV_W];

endmodule

FILE: rtl/esc_post.sv
module esc_post import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  esc_trim_t   trim,
  input  logic        in_valid,
  input  logic [31:0] quotient,
  input  esc_side_t   in_side,
  esc_result_if.source result
);

  logic [2:1] vld;
  logic signed [31:0] p_w, s_w;
  logic signed [31:0] q1_p, q1_pp, q1_r2m, q1_hq, q2_p, q2_r1m, q2_r2m, q2_hq2;
  esc_side_t q1_side, q2_side;
  logic signed [31:0] pf_w, hv2_w, hv3_w;
  logic [26:0] hs_w;

  assign p_w = in_side.mul2 ? $signed(quotient << 1) : $signed(quotient);
  assign s_w = in_side.hv >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[1], in_valid};
      result.valid <= vld[2];
    end
  end

  // pressure correction terms and humidity square term
  always_ff @(posedge clk) begin
    if (en) begin
      q1_p    <= p_w;
      q1_pp   <= (p_w >> 3) * (p_w >> 3);
      q1_r2m  <= (p_w >> 2) * trim.p8;
      q1_hq   <= s_w * s_w;
      q1_side <= in_side;

      q2_p    <= q1_p;
      q2_r1m  <= trim.p9 * (q1_pp >> 13);
      q2_r2m  <= q1_r2m;
      q2_hq2  <= (q1_hq >>> 7) * trim.h1;
      q2_side <= q1_side;
    end
  end

  assign pf_w  = q2_p + (((q2_r1m >>> 12) + (q2_r2m >>> 13) + trim.p7) >>> 4);
  assign hv2_w = q2_side.hv - (q2_hq2 >>> 4);
  assign hv3_w = hv2_w[31] ? 32'sd0 : ((hv2_w > HUM_MAX) ? HUM_MAX : hv2_w);
  assign hs_w  = 27'(hv3_w[28:12]) * 27'd100 + 27'd512;

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (q2_side.skip) begin
        result.temperature_centi_c <= '0;
        result.humidity_centi_pct  <= '0;
        result.pressure_pa         <= '0;
        result.pressure_valid      <= 1'b0;
        result.reading_valid       <= 1'b0;
      end else begin
        result.temperature_centi_c <= q2_side.temp;
        result.humidity_centi_pct  <= hs_w[23:10];
        result.pressure_pa         <= q2_side.dz ? 32'd0 : pf_w;
        result.pressure_valid      <= !q2_side.dz;
        result.reading_valid       <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/env_sensor_compensation.sv
// Environmental sensor compensation pipeline.
// sample channel: one raw pressure, temperature and humidity code per item.
// result channel: temperature in 0.01 degC, humidity in 0.01 %RH, pressure
//   in Pa with its valid flag, and a reading valid flag that is low for an
//   unmeasured sample (all other fields are then zero).
// cfg channel: index 0..4 selects a packed trimming register, always ready;
//   writes to other indexes are dropped. Write only while no item is in flight.
// The path from sample accept to result valid has 11 stages of
// temperature/humidity/pressure arithmetic, 32 stages of the radix-2
// pressure divider, 3 stages of final correction and output register.
// Throughput is one item per cycle while the receiver takes results; the
// divider with one quotient bit per stage sets the depth.
// Reset clears all valid bits and the trimming registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and sample.ready drops; nothing is lost or repeated.
module env_sensor_compensation import esc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  esc_sample_if.sink   sample,
  esc_result_if.source result,
  esc_cfg_if.sink      cfg
);

  logic [47:0] trim_t;
  logic [63:0] trim_pl, trim_ph;
  logic [47:0] trim_mx;
  logic [39:0] trim_h;
  esc_trim_t   trim;
  logic        en;

  logic        f_valid, d_valid;
  logic [31:0] f_dividend, f_divisor, d_quo;
  esc_side_t   f_side, d_side;

  // trimming registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_t  <= '0;
      trim_pl <= '0;
      trim_ph <= '0;
      trim_mx <= '0;
      trim_h  <= '0;
    end else if (cfg.valid) begin
      unique case (esc_reg_t'(cfg.index))
        REG_TRIM_T:  trim_t  <= cfg.data[47:0];
        REG_TRIM_PL: trim_pl <= cfg.data;
        REG_TRIM_PH: trim_ph <= cfg.data;
        REG_TRIM_MX: trim_mx <= cfg.data[47:0];
        REG_TRIM_H:  trim_h  <= cfg.data[39:0];
        default: ;
      endcase
    end
  end

  assign trim = decode_trim(trim_t, trim_pl, trim_ph, trim_mx, trim_h);

  // whole pipeline advances unless the output is held
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  esc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .trim            (trim),
    .in_valid        (sample.valid),
    .raw_pressure    (sample.raw_pressure),
    .raw_temperature (sample.raw_temperature),
    .raw_humidity    (sample.raw_humidity),
    .out_valid       (f_valid),
    .dividend        (f_dividend),
    .divisor         (f_divisor),
    .side            (f_side)
  );

  esc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .dividend  (f_dividend),
    .divisor   (f_divisor),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quotient  (d_quo),
    .out_side  (d_side)
  );

  esc_post u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .trim     (trim),
    .in_valid (d_valid),
    .quotient (d_quo),
    .in_side  (d_side),
    .result   (result)
  );

endmodule
